[rtl/core/bpa_pkg.sv]
package bpa_pkg;

    localparam int DEF_MAX_PAGES   = 4096;
    localparam int DEF_ORDER_LIMIT = 16;
    localparam int ORD_W           = 5;

    localparam logic [12:0]      PAGE_COUNT_RESET = 13'd4096;
    localparam logic [ORD_W-1:0] NOT_ALLOC        = 5'd31;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOMEM    = 2'd1;
    localparam logic [1:0] ST_NOTALLOC = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  order;
        logic [11:0] first_index;
        logic [12:0] end_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] block_index;
        logic [3:0]  block_order;
    } t_res;

    typedef struct packed {
        logic             in_free;
        logic [ORD_W-1:0] fbo;
        logic [ORD_W-1:0] alloc;
    } t_flag;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_CHK,
        S_ADD_RD,
        S_PUSH0,
        S_PUSH1,
        S_PUSH2,
        S_UNL0,
        S_UNL1,
        S_ALC_START,
        S_ALC_SRCH,
        S_ALC_SPLIT,
        S_ALC_SPL2,
        S_ALC_SPL3,
        S_ALC_MARK,
        S_FRE_START,
        S_FRE_RD,
        S_FRE_CHK,
        S_FRE_BRD,
        S_FRE_MRG,
        S_FRE_END,
        S_FIN
    } t_state;

endpackage

[rtl/core/buddy_page_allocator.sv]
// Buddy page allocator.
// Requests enter on the in channel (valid/ready) as one transaction each: add a free
// range, allocate a block of a given order, or free a block. Every request yields
// exactly one result transaction on the out channel with a status, a block index and
// a block order. The page_count register is written through i_cfg_we/i_cfg_data.
// All per-page state lives in three single-port-write memories with a registered
// read; a sequencer walks the orders and updates the linked free lists. A push reads
// the page flag and, if the page is not yet free, links it at its order's list tail;
// an unlink reads the flag and both links, then unhooks the page. An add pushes each
// aligned block it carves that is neither free nor allocated; an allocate searches
// the orders upward and splits down to the requested order; a free merges with free
// buddies and then pushes the result. Requests are handled one at a time; ready is
// high only while the sequencer is idle. After reset the block sweeps the page flag
// memory once with ready low; configuration writes are taken during the sweep.
// A finished result sits in the output register; the next request is accepted while
// it waits. When the receiver stalls and a second result is done, the sequencer holds
// until the output register drains.
module buddy_page_allocator #(
    parameter int MAX_PAGES   = bpa_pkg::DEF_MAX_PAGES,
    parameter int ORDER_LIMIT = bpa_pkg::DEF_ORDER_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  bpa_pkg::t_req i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output bpa_pkg::t_res o_out_data,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data
);
    import bpa_pkg::*;

    localparam int PW  = $clog2(MAX_PAGES);
    localparam int LW  = PW + 1;
    localparam int XW  = (PW + 1 > 13) ? PW + 1 : 13;
    localparam int OIW = $clog2(ORDER_LIMIT);
    localparam int FW  = $bits(t_flag);

    localparam logic [LW-1:0]    NIL     = LW'(MAX_PAGES);
    localparam logic [ORD_W-1:0] OLIM    = ORD_W'(ORDER_LIMIT);
    localparam logic [XW-1:0]    MAX_EXT = XW'(MAX_PAGES);

    function automatic logic [ORD_W-1:0] f_len_order(input logic [XW-1:0] len);
        logic [ORD_W-1:0] o;
        o = '0;
        for (int b = 1; b < XW; b++) begin
            if (len[b]) begin
                o = (b < ORDER_LIMIT) ? ORD_W'(b) : ORD_W'(ORDER_LIMIT - 1);
            end
        end
        return o;
    endfunction

    function automatic logic [ORD_W-1:0] f_idx_order(input logic [XW-1:0] idx);
        logic [ORD_W-1:0] o;
        o = ORD_W'(ORDER_LIMIT - 1);
        for (int b = ORDER_LIMIT - 2; b >= 0; b--) begin
            if (|(idx & (XW'(1) << b))) begin
                o = ORD_W'(b);
            end
        end
        return o;
    endfunction

    t_state           r_state, n_state, r_ret, n_ret;
    t_req             r_req, n_req;
    t_res             r_res, n_res, r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [XW-1:0]    r_aidx, n_aidx, r_to, n_to;
    logic [PW-1:0]    r_idx, n_idx, r_bud, n_bud, r_p_idx, n_p_idx, r_t, n_t;
    logic [ORD_W-1:0] r_o, n_o, r_p_ord, n_p_ord;
    logic [PW:0]      r_clr, n_clr;
    logic [12:0]      r_page_count;
    logic [LW-1:0]    r_head [ORDER_LIMIT];
    logic [LW-1:0]    r_tail [ORDER_LIMIT];

    logic             fl_we, fl_re, nx_we, nx_re, pv_we, pv_re;
    logic [PW-1:0]    fl_wa, fl_ra, nx_wa, nx_ra, pv_wa, pv_ra;
    t_flag            fl_wd, fl_rd;
    logic [FW-1:0]    fl_rd_raw;
    logic [LW-1:0]    nx_wd, nx_rd, pv_wd, pv_rd;
    logic             hd_we, tl_we;
    logic [OIW-1:0]   hd_wa, tl_wa;
    logic [LW-1:0]    hd_wd, tl_wd;

    logic [XW-1:0]    eff, pc_ext, end_ext, len;
    logic [ORD_W-1:0] ord_a, ord_b;
    logic [LW-1:0]    tail_q, head_q;
    logic [PW-1:0]    bud;

    assign fl_rd = t_flag'(fl_rd_raw);

    bpa_ram #(.DW(FW), .AW(PW)) u_flag (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_wa), .i_wdata(fl_wd),
        .i_re(fl_re), .i_raddr(fl_ra), .o_rdata(fl_rd_raw)
    );

    bpa_ram #(.DW(LW), .AW(PW)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_re(nx_re), .i_raddr(nx_ra), .o_rdata(nx_rd)
    );

    bpa_ram #(.DW(LW), .AW(PW)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_re(pv_re), .i_raddr(pv_ra), .o_rdata(pv_rd)
    );

    assign pc_ext  = XW'(r_page_count);
    assign eff     = (pc_ext > MAX_EXT) ? MAX_EXT : pc_ext;
    assign end_ext = XW'(i_in_data.end_index);
    assign len     = r_to - r_aidx;
    assign ord_a   = f_len_order(len);
    assign ord_b   = f_idx_order(r_aidx);
    assign tail_q  = r_tail[r_p_ord[OIW-1:0]];
    assign head_q  = r_head[r_o[OIW-1:0]];
    assign bud     = r_idx ^ (PW'(1) << r_o);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_ret        <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_clr        <= '0;
            r_page_count <= PAGE_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
            r_clr       <= n_clr;
            if (i_cfg_we) begin
                r_page_count <= i_cfg_data;
            end
        end
        r_req   <= n_req;
        r_res   <= n_res;
        r_out   <= n_out;
        r_aidx  <= n_aidx;
        r_to    <= n_to;
        r_idx   <= n_idx;
        r_bud   <= n_bud;
        r_p_idx <= n_p_idx;
        r_t     <= n_t;
        r_o     <= n_o;
        r_p_ord <= n_p_ord;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ORDER_LIMIT; k++) begin
                r_head[k] <= NIL;
                r_tail[k] <= NIL;
            end
        end else begin
            if (hd_we) begin
                r_head[hd_wa] <= hd_wd;
            end
            if (tl_we) begin
                r_tail[tl_wa] <= tl_wd;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_aidx      = r_aidx;
        n_to        = r_to;
        n_idx       = r_idx;
        n_bud       = r_bud;
        n_p_idx     = r_p_idx;
        n_t         = r_t;
        n_o         = r_o;
        n_p_ord     = r_p_ord;
        n_clr       = r_clr;
        fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_re = 1'b0; fl_ra = '0;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_re = 1'b0; nx_ra = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_re = 1'b0; pv_ra = '0;
        hd_we = 1'b0; hd_wa = '0; hd_wd = '0;
        tl_we = 1'b0; tl_wa = '0; tl_wd = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                fl_we = 1'b1;
                fl_wa = r_clr[PW-1:0];
                fl_wd = '{in_free: 1'b0, fbo: '0, alloc: NOT_ALLOC};
                n_clr = r_clr + 1'b1;
                if (r_clr == (PW+1)'(MAX_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req = i_in_data;
                    n_res = '0;
                    unique case (i_in_data.mode)
                        MODE_ADD: begin
                            n_aidx  = XW'(i_in_data.first_index);
                            n_to    = (end_ext < eff) ? end_ext : eff;
                            n_state = S_ADD_CHK;
                        end
                        MODE_ALLOC: n_state = S_ALC_START;
                        MODE_FREE:  n_state = S_FRE_START;
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_ADD_CHK: begin
                if (r_aidx < r_to) begin
                    n_o     = (ord_a < ord_b) ? ord_a : ord_b;
                    fl_re   = 1'b1;
                    fl_ra   = PW'(r_aidx);
                    n_state = S_ADD_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ADD_RD: begin
                n_aidx = r_aidx + (XW'(1) << r_o);
                if (!fl_rd.in_free && fl_rd.alloc == NOT_ALLOC) begin
                    n_p_idx = PW'(r_aidx);
                    n_p_ord = r_o;
                    n_ret   = S_ADD_CHK;
                    n_state = S_PUSH0;
                end else begin
                    n_state = S_ADD_CHK;
                end
            end
            S_PUSH0: begin
                fl_re   = 1'b1;
                fl_ra   = r_p_idx;
                n_state = S_PUSH1;
            end
            S_PUSH1: begin
                if (fl_rd.in_free) begin
                    n_state = r_ret;
                end else begin
                    pv_we = 1'b1; pv_wa = r_p_idx; pv_wd = tail_q;
                    nx_we = 1'b1; nx_wa = r_p_idx; nx_wd = NIL;
                    fl_we = 1'b1; fl_wa = r_p_idx;
                    fl_wd = '{in_free: 1'b1, fbo: r_p_ord, alloc: fl_rd.alloc};
                    tl_we = 1'b1; tl_wa = r_p_ord[OIW-1:0]; tl_wd = {1'b0, r_p_idx};
                    if (tail_q[PW]) begin
                        hd_we   = 1'b1;
                        hd_wa   = r_p_ord[OIW-1:0];
                        hd_wd   = {1'b0, r_p_idx};
                        n_state = r_ret;
                    end else begin
                        n_t     = tail_q[PW-1:0];
                        n_state = S_PUSH2;
                    end
                end
            end
            S_PUSH2: begin
                nx_we   = 1'b1;
                nx_wa   = r_t;
                nx_wd   = {1'b0, r_p_idx};
                n_state = r_ret;
            end
            S_UNL0: begin
                fl_re = 1'b1; fl_ra = r_p_idx;
                nx_re = 1'b1; nx_ra = r_p_idx;
                pv_re = 1'b1; pv_ra = r_p_idx;
                n_state = S_UNL1;
            end
            S_UNL1: begin
                if (fl_rd.in_free) begin
                    fl_we = 1'b1;
                    fl_wa = r_p_idx;
                    fl_wd = '{in_free: 1'b0, fbo: fl_rd.fbo, alloc: fl_rd.alloc};
                    if (!pv_rd[PW]) begin
                        nx_we = 1'b1; nx_wa = pv_rd[PW-1:0]; nx_wd = nx_rd;
                    end else begin
                        hd_we = 1'b1; hd_wa = fl_rd.fbo[OIW-1:0]; hd_wd = nx_rd;
                    end
                    if (!nx_rd[PW]) begin
                        pv_we = 1'b1; pv_wa = nx_rd[PW-1:0]; pv_wd = pv_rd;
                    end else begin
                        tl_we = 1'b1; tl_wa = fl_rd.fbo[OIW-1:0]; tl_wd = pv_rd;
                    end
                end
                n_state = r_ret;
            end
            S_ALC_START: begin
                if ({1'b0, r_req.order} >= OLIM) begin
                    n_res.status = ST_NOMEM;
                    n_state      = S_FIN;
                end else begin
                    n_o     = ORD_W'(r_req.order);
                    n_state = S_ALC_SRCH;
                end
            end
            S_ALC_SRCH: begin
                priority if (r_o == OLIM) begin
                    n_res.status = ST_NOMEM;
                    n_state      = S_FIN;
                end else if (!head_q[PW]) begin
                    n_state = S_ALC_SPLIT;
                end else begin
                    n_o = r_o + 1'b1;
                end
            end
            S_ALC_SPLIT: begin
                n_idx   = head_q[PW-1:0];
                n_p_idx = head_q[PW-1:0];
                n_ret   = (r_o > ORD_W'(r_req.order)) ? S_ALC_SPL2 : S_ALC_MARK;
                n_state = S_UNL0;
            end
            S_ALC_SPL2: begin
                n_o     = r_o - 1'b1;
                n_p_idx = r_idx;
                n_p_ord = r_o - 1'b1;
                n_ret   = S_ALC_SPL3;
                n_state = S_PUSH0;
            end
            S_ALC_SPL3: begin
                n_p_idx = bud;
                n_p_ord = r_o;
                n_ret   = S_ALC_SPLIT;
                n_state = S_PUSH0;
            end
            S_ALC_MARK: begin
                fl_we = 1'b1;
                fl_wa = r_idx;
                fl_wd = '{in_free: 1'b0, fbo: fl_rd.fbo, alloc: ORD_W'(r_req.order)};
                n_res.status      = ST_OK;
                n_res.block_index = 12'(r_idx);
                n_res.block_order = r_req.order;
                n_state           = S_FIN;
            end
            S_FRE_START: begin
                if (XW'(r_req.first_index) >= MAX_EXT) begin
                    n_res.status = ST_NOTALLOC;
                    n_state      = S_FIN;
                end else begin
                    fl_re   = 1'b1;
                    fl_ra   = PW'(r_req.first_index);
                    n_state = S_FRE_RD;
                end
            end
            S_FRE_RD: begin
                if (fl_rd.alloc >= OLIM) begin
                    n_res.status = ST_NOTALLOC;
                    n_state      = S_FIN;
                end else begin
                    fl_we = 1'b1;
                    fl_wa = PW'(r_req.first_index);
                    fl_wd = '{in_free: fl_rd.in_free, fbo: fl_rd.fbo, alloc: NOT_ALLOC};
                    n_idx   = PW'(r_req.first_index);
                    n_o     = fl_rd.alloc;
                    n_state = S_FRE_CHK;
                end
            end
            S_FRE_CHK: begin
                n_bud = bud;
                if ((r_o + 1'b1 >= OLIM) || (6'(r_o) >= 6'(PW)) || (XW'(bud) >= eff)) begin
                    n_p_idx = r_idx;
                    n_p_ord = r_o;
                    n_ret   = S_FRE_END;
                    n_state = S_PUSH0;
                end else begin
                    fl_re   = 1'b1;
                    fl_ra   = bud;
                    n_state = S_FRE_BRD;
                end
            end
            S_FRE_BRD: begin
                if (!fl_rd.in_free || fl_rd.fbo != r_o) begin
                    n_p_idx = r_idx;
                    n_p_ord = r_o;
                    n_ret   = S_FRE_END;
                end else begin
                    n_p_idx = r_bud;
                    n_ret   = S_FRE_MRG;
                end
                n_state = (!fl_rd.in_free || fl_rd.fbo != r_o) ? S_PUSH0 : S_UNL0;
            end
            S_FRE_MRG: begin
                n_idx   = r_idx & ~(PW'(1) << r_o);
                n_o     = r_o + 1'b1;
                n_state = S_FRE_CHK;
            end
            S_FRE_END: begin
                n_res.status      = ST_OK;
                n_res.block_index = 12'(r_idx);
                n_res.block_order = 4'(r_o);
                n_state           = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/core/bpa_ram.sv]
module bpa_ram #(
    parameter int DW = 8,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bpa_check.sv]
module bpa_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input bpa_pkg::t_res o_out_data
);
    import bpa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Result changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Second request accepted while busy.");

    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("Ready during the reset sweep.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.block_index == '0 && o_out_data.block_order == '0)
        else $error("Failed result carries a block.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status == ST_OK || o_out_data.status == ST_NOMEM ||
            o_out_data.status == ST_NOTALLOC)
        else $error("Unknown status code.");

endmodule

bind buddy_page_allocator bpa_check u_bpa_check (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data(o_out_data)
);

[verif/tb_buddy_page_allocator.sv]
`timescale 1ns / 1ps

module tb_buddy_page_allocator;
    import bpa_pkg::*;

    localparam int NPAGES    = DEF_MAX_PAGES;
    localparam int NORDERS   = DEF_ORDER_LIMIT;
    localparam int IDLE_LIMIT = 30000;

    typedef struct {
        t_req req;
        bit   known;
        t_res res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_req        i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_res        o_out_data;
    logic        i_cfg_we;
    logic [12:0] i_cfg_data;

    buddy_page_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the allocator state.
    logic [12:0] sh_next[NPAGES];
    logic [12:0] sh_prev[NPAGES];
    bit          sh_listed[NPAGES];
    logic [3:0]  sh_free_ord[NPAGES];
    logic [4:0]  sh_alloc_ord[NPAGES];
    logic [12:0] sh_head[NORDERS];
    logic [12:0] sh_tail[NORDERS];
    int unsigned sh_pages;

    t_res        pending_results[$];
    int unsigned live_blocks[$];
    int          mismatches;
    bit          hold_output;
    int          idle_cycles;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned usable_pages();
        return (sh_pages > NPAGES) ? NPAGES : sh_pages;
    endfunction

    function automatic void list_append(int unsigned idx, int unsigned o);
        int unsigned t;
        if (idx >= NPAGES || o >= NORDERS || sh_listed[idx]) return;
        t = sh_tail[o];
        sh_prev[idx] = t;
        sh_next[idx] = NPAGES;
        if (t < NPAGES) sh_next[t] = idx;
        else sh_head[o] = idx;
        sh_tail[o] = idx;
        sh_listed[idx] = 1'b1;
        sh_free_ord[idx] = o;
    endfunction

    function automatic void list_drop(int unsigned idx);
        int unsigned o, p, n;
        if (idx >= NPAGES || !sh_listed[idx]) return;
        o = sh_free_ord[idx];
        p = sh_prev[idx];
        n = sh_next[idx];
        if (p < NPAGES) sh_next[p] = n;
        else sh_head[o] = n;
        if (n < NPAGES) sh_prev[n] = p;
        else sh_tail[o] = p;
        sh_listed[idx] = 1'b0;
    endfunction

    function automatic t_res predict_result(t_req r);
        t_res        res;
        int unsigned lim, idx, o, a, b, req, buddy;
        res = '0;
        req = r.order;
        if (r.mode == MODE_ADD) begin
            lim = (r.end_index < usable_pages()) ? r.end_index : usable_pages();
            idx = r.first_index;
            while (idx < lim) begin
                a = 0;
                while (a + 1 < NORDERS && (1 << (a + 1)) <= lim - idx) a++;
                b = 0;
                while (b + 1 < NORDERS && !((idx >> b) & 1)) b++;
                o = (a < b) ? a : b;
                if (!sh_listed[idx] && sh_alloc_ord[idx] == NOT_ALLOC) list_append(idx, o);
                idx += 1 << o;
            end
        end else if (r.mode == MODE_ALLOC) begin
            o = req;
            while (o < NORDERS && sh_head[o] >= NPAGES) o++;
            if (o >= NORDERS) begin
                res.status = ST_NOMEM;
            end else begin
                while (o > req) begin
                    idx = sh_head[o];
                    list_drop(idx);
                    o--;
                    list_append(idx, o);
                    list_append(idx ^ (1 << o), o);
                end
                idx = sh_head[req];
                list_drop(idx);
                sh_alloc_ord[idx] = req;
                res.block_index = idx;
                res.block_order = req;
                live_blocks.push_back(idx);
            end
        end else if (r.mode == MODE_FREE) begin
            idx = r.first_index;
            if (sh_alloc_ord[idx] >= NORDERS) begin
                res.status = ST_NOTALLOC;
            end else begin
                o = sh_alloc_ord[idx];
                sh_alloc_ord[idx] = NOT_ALLOC;
                while (o + 1 < NORDERS) begin
                    buddy = idx ^ (1 << o);
                    if (buddy >= usable_pages() || !sh_listed[buddy] || sh_free_ord[buddy] != o)
                        break;
                    list_drop(buddy);
                    idx &= ~(1 << o);
                    o++;
                end
                list_append(idx, o);
                res.block_index = idx;
                res.block_order = o;
            end
        end
        return res;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick, k;
        r = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            r.mode = MODE_ADD;
            if ($urandom_range(0, 19) == 0) begin
                r.end_index = $urandom_range(4096, 8191);
            end else begin
                r.end_index = r.first_index + $urandom_range(0, 64);
            end
        end else if (pick < 60) begin
            r.mode = MODE_ALLOC;
            if ($urandom_range(0, 9) != 0) r.order = $urandom_range(0, 4);
        end else if (pick < 90 && live_blocks.size() > 0) begin
            r.mode = MODE_FREE;
            k = $urandom_range(0, live_blocks.size() - 1);
            r.first_index = live_blocks[k];
            live_blocks.delete(k);
        end else if (pick < 97) begin
            r.mode = MODE_FREE;
        end else begin
            r.mode = MODE_NONE;
        end
        return r;
    endfunction

    task automatic send_request(t_req r);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_result(r));
    endtask

    task automatic idle_input(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_and_configure(logic [12:0] pages);
        idle_input(0);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= pages;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sh_pages = pages;
    endtask

    // Receiver: a changing stall pattern, plus one long hold when asked.
    initial begin
        int unsigned tick, style;
        tick = 0;
        style = 0;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                i_out_ready <= 1'b0;
                repeat (500) @(posedge i_clk);
                hold_output = 1'b0;
            end else begin
                tick++;
                if (tick % 64 == 0) style = $urandom_range(0, 3);
                case (style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= $urandom_range(0, 1);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= (tick % 8 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out_data.status !== exp_res.status
                        || o_out_data.block_index !== exp_res.block_index
                        || o_out_data.block_order !== exp_res.block_order) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_res, o_out_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row        rows[$];
        t_res        got;
        logic [12:0] settings[8];
        int          burst;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        mismatches  = 0;
        hold_output = 1'b0;
        idle_cycles = 0;
        for (int i = 0; i < NPAGES; i++) begin
            sh_listed[i] = 1'b0;
            sh_alloc_ord[i] = NOT_ALLOC;
            sh_next[i] = '0;
            sh_prev[i] = '0;
            sh_free_ord[i] = '0;
        end
        for (int i = 0; i < NORDERS; i++) begin
            sh_head[i] = NPAGES;
            sh_tail[i] = NPAGES;
        end
        sh_pages = PAGE_COUNT_RESET;

        rows = '{
            '{'{MODE_ALLOC, 4'd0, 12'd0, 13'd0},       1, '{ST_NOMEM, 12'd0, 4'd0}},
            '{'{MODE_FREE, 4'd0, 12'd0, 13'd0},        1, '{ST_NOTALLOC, 12'd0, 4'd0}},
            '{'{MODE_ALLOC, 4'd15, 12'd4095, 13'd8191}, 1, '{ST_NOMEM, 12'd0, 4'd0}},
            '{'{MODE_NONE, 4'd15, 12'd4095, 13'd8191}, 1, '{ST_OK, 12'd0, 4'd0}},
            '{'{MODE_ADD, 4'd0, 12'd0, 13'd4096},      1, '{ST_OK, 12'd0, 4'd0}},
            '{'{MODE_ALLOC, 4'd0, 12'd0, 13'd0},       0, '0},
            '{'{MODE_ALLOC, 4'd15, 12'd0, 13'd0},      1, '{ST_NOMEM, 12'd0, 4'd0}},
            '{'{MODE_ALLOC, 4'd3, 12'd0, 13'd0},       0, '0},
            '{'{MODE_FREE, 4'd0, 12'd0, 13'd0},        0, '0},
            '{'{MODE_FREE, 4'd0, 12'd0, 13'd0},        1, '{ST_NOTALLOC, 12'd0, 4'd0}},
            '{'{MODE_ADD, 4'd0, 12'd0, 13'd4096},      1, '{ST_OK, 12'd0, 4'd0}},
            '{'{MODE_ADD, 4'd0, 12'd100, 13'd50},      1, '{ST_OK, 12'd0, 4'd0}},
            '{'{MODE_ADD, 4'd0, 12'd4000, 13'd8191},   1, '{ST_OK, 12'd0, 4'd0}},
            '{'{MODE_ALLOC, 4'd11, 12'd0, 13'd0},      0, '0},
            '{'{MODE_ALLOC, 4'd1, 12'd0, 13'd0},       0, '0},
            '{'{MODE_ALLOC, 4'd0, 12'd0, 13'd0},       0, '0},
            '{'{MODE_FREE, 4'd0, 12'd4095, 13'd0},     1, '{ST_NOTALLOC, 12'd0, 4'd0}},
            '{'{MODE_ALLOC, 4'd12, 12'd0, 13'd0},      0, '0},
            '{'{MODE_NONE, 4'd0, 12'd0, 13'd0},        1, '{ST_OK, 12'd0, 4'd0}}
        };
        settings = '{13'd4096, 13'd13, 13'd0, 13'd1, 13'd4095, 13'd8191, 13'd2048, 13'd4096};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain_and_configure(PAGE_COUNT_RESET);

        foreach (rows[i]) begin
            send_request(rows[i].req);
            if (rows[i].known) begin
                got = pending_results[$];
                if (got !== rows[i].res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: table says %p, predictor %p", i, rows[i].res, got);
                end
            end
        end

        foreach (settings[p]) begin
            drain_and_configure(settings[p]);
            burst = $urandom_range(1, 40);
            for (int n = 0; n < 215; n++) begin
                if ((p == 1 || p == 6) && n == 40) hold_output = 1'b1;
                if (burst == 0) begin
                    if (p % 2 == 0) idle_input($urandom_range(1, 12));
                    burst = $urandom_range(1, 40);
                end
                send_request(random_request());
                burst--;
            end
        end

        idle_input(0);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
